### design/sac_pkg.sv
package sac_pkg;

    // Internal time word: signed, with +/- 2^62 standing for infinity
    localparam int TIME_W = 64;
    localparam int TIME_SAT_BIT = 62;
    localparam logic signed [TIME_W-1:0] TIME_INF = 64'sh4000_0000_0000_0000;

    // Split of the time magnitude for the contact-point partial products
    localparam int BL_W = 32;

    typedef enum logic [2:0] {
        NRM_NONE = 3'd0,
        NRM_PX   = 3'd1,
        NRM_MX   = 3'd2,
        NRM_PY   = 3'd3,
        NRM_MY   = 3'd4
    } t_normal;

endpackage

### design/sac_if.sv
interface sac_in_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] mov_x;
    logic signed [CW-1:0] mov_y;
    logic        [CW-2:0] mov_w;
    logic        [CW-2:0] mov_h;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] st_x;
    logic signed [CW-1:0] st_y;
    logic        [CW-2:0] st_w;
    logic        [CW-2:0] st_h;

    modport source (
        output valid, mov_x, mov_y, mov_w, mov_h, vel_x, vel_y, st_x, st_y, st_w, st_h,
        input  ready
    );
    modport sink (
        input  valid, mov_x, mov_y, mov_w, mov_h, vel_x, vel_y, st_x, st_y, st_w, st_h,
        output ready
    );
endinterface

interface sac_out_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
    logic        [2:0]    normal_code;
    logic signed [CW-1:0] hit_time;

    modport source (
        output valid, hit, contact_x, contact_y, normal_code, hit_time,
        input  ready
    );
    modport sink (
        input  valid, hit, contact_x, contact_y, normal_code, hit_time,
        output ready
    );
endinterface

### design/sac_div.sv
module sac_div #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [CW+1:0]       i_mag,
    input  logic [CW-1:0]       i_den,
    output logic [CW+FB+1:0]    o_quo
);
    localparam int MB = CW + 2;
    localparam int QB = MB + FB;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [QB-1:0] quo;
    } t_step;

    logic [CW-1:0] r_rem [QB-1];
    logic [CW-1:0] r_den [QB-1];
    logic [QB-1:0] r_quo [QB];
    t_step         w_nxt [QB];

    // One restoring step: bring down the next dividend bit, subtract if it fits
    function automatic t_step f_step(input logic [CW-1:0] rin, input logic [QB-1:0] qin,
                                     input logic [CW-1:0] din);
        logic [CW:0] t;
        logic [CW:0] d;
        logic        ge;
        t_step       s;
        t  = {rin, qin[QB-1]};
        d  = {1'b0, din};
        ge = (t >= d);
        s.rem = ge ? CW'(t - d) : t[CW-1:0];
        s.quo = {qin[QB-2:0], ge};
        return s;
    endfunction

    // Work out every stage from the registers before it
    always_comb begin
        w_nxt[0] = f_step('0, {i_mag, {FB{1'b0}}}, i_den);
        for (int k = 1; k < QB; k++) begin
            w_nxt[k] = f_step(r_rem[k-1], r_quo[k-1], r_den[k-1]);
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int k = 1; k < QB - 1; k++) begin
                r_den[k] <= r_den[k-1];
            end
            for (int k = 0; k < QB - 1; k++) begin
                r_rem[k] <= w_nxt[k].rem;
            end
            for (int k = 0; k < QB; k++) begin
                r_quo[k] <= w_nxt[k].quo;
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

### design/swept_aabb_collision.sv
// Swept box test: a moving box, its velocity step and a static box go in on
// the i_in channel; one result per transaction comes out on o_out: hit flag,
// contact point, face normal code and entry time, the point and the time in
// signed fixed point. Both channels use valid/ready; a transaction moves when
// both are high. One transaction is accepted per cycle while the skid entry is
// free. The four slab divisions run as long-division pipelines that retire
// one quotient bit per stage. All stages advance together.
// The output register is backed by one skid entry, so a stalled receiver
// parks at most one result there, and i_in.ready drops in the next cycle
// and stays low until the skid entry is drained.
// No result is lost or repeated across a stall.
// Reset (i_rst_n low at a clock edge) empties the pipeline and the skid
// entry; the block accepts transactions in the first cycle after reset.
module swept_aabb_collision #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sac_in_if.sink    i_in,
    sac_out_if.source o_out
);
    import sac_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int NW = CW + 3;
    localparam int MB = CW + 2;
    localparam int QB = MB + FB;
    localparam int QX = (QB > TIME_SAT_BIT + 1) ? QB : TIME_SAT_BIT + 1;
    localparam int PW = CW + TIME_W - 1;
    localparam int PH = CW + TIME_W - 1 - BL_W;
    localparam int SW = TIME_W + 1;
    localparam logic [TIME_W-2:0] MAG_INF = (TIME_W-1)'(TIME_INF);
    localparam logic signed [SW-1:0] C_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] C_LO = ~C_HI;
    localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(1) << FB;

    typedef struct packed {
        logic [3:0][NW-1:0] num;
        logic signed [CW:0]   ox;
        logic signed [CW:0]   oy;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic                 vz;
    } t_sa;

    typedef struct packed {
        logic                 ok;
        logic signed [CW:0]   ox;
        logic signed [CW:0]   oy;
        logic                 vxneg;
        logic                 vyneg;
        logic [CW-1:0]        ax;
        logic [CW-1:0]        ay;
        logic                 dzx;
        logic                 dzy;
        logic [3:0]           nneg;
    } t_side;

    typedef struct packed {
        logic                     ok;
        logic                     disj;
        logic                     gt;
        logic                     lt;
        logic                     xlt;
        logic                     vxneg;
        logic                     vyneg;
        logic signed [CW:0]       ox;
        logic signed [CW:0]       oy;
        logic [CW-1:0]            ax;
        logic [CW-1:0]            ay;
        logic signed [TIME_W-1:0] enx;
        logic signed [TIME_W-1:0] exx;
        logic signed [TIME_W-1:0] eny;
        logic signed [TIME_W-1:0] exy;
        logic signed [TIME_W-1:0] tin;
        logic signed [TIME_W-1:0] tout;
        logic [TIME_W-2:0]        tb;
        logic [CW+BL_W-1:0]       pxl;
        logic [CW+BL_W-1:0]       pyl;
        logic [PH-1:0]            pxh;
        logic [PH-1:0]            pyh;
        logic [TIME_W-2:0]        magx;
        logic [TIME_W-2:0]        magy;
    } t_pst;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        t_normal              code;
        logic signed [CW-1:0] ht;
    } t_res;

    // Quotient to internal time, with infinity for overflow and zero divisors
    function automatic logic signed [TIME_W-1:0] f_time(input logic [QB-1:0] q,
                                                        input logic neg, input logic dz);
        logic [QX-1:0]            qe;
        logic signed [TIME_W-1:0] m;
        qe = QX'(q);
        if (dz || (|qe[QX-1:TIME_SAT_BIT])) begin
            m = TIME_INF;
        end else begin
            m = TIME_W'(qe[TIME_SAT_BIT-1:0]);
        end
        return neg ? -m : m;
    endfunction

    // Product to displacement magnitude, clamped at infinity
    function automatic logic [TIME_W-2:0] f_mag(input logic [PW-1:0] p);
        logic over;
        over = (|p[PW-1:TIME_SAT_BIT+1]) ||
               (p[TIME_SAT_BIT] && (|p[TIME_SAT_BIT-1:0]));
        return over ? MAG_INF : (TIME_W-1)'(p >> FB);
    endfunction

    function automatic logic signed [CW-1:0] f_satc(input logic signed [SW-1:0] v);
        if (v > C_HI) begin
            return CW'(C_HI);
        end else if (v < C_LO) begin
            return CW'(C_LO);
        end
        return CW'(v);
    endfunction

    logic w_en;
    logic w_push;

    logic  r_a_vld;
    t_sa   r_a;
    t_sa   n_a;
    logic  r_b_vld;
    logic [3:0][MB-1:0] r_b_mag;
    logic [3:0][MB-1:0] n_b_mag;
    t_side r_b_side;
    t_side n_b_side;
    logic  r_dv [QB];
    t_side r_sd [QB];
    logic [QB-1:0] w_quo [4];
    logic  r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld, r_h_vld;
    t_pst  r_c, r_d, r_e, r_f, r_g, r_h;
    t_pst  n_c, n_d, n_e, n_f, n_g, n_h;
    t_res  w_res;
    logic  r_ov, r_sv;
    logic  n_ov, n_sv;
    t_res  r_od, r_skd;
    t_res  n_od, n_skd;

    // All stages move while the skid entry is free
    assign w_en       = !r_sv;
    assign i_in.ready = w_en;
    assign w_push     = w_en && r_h_vld;

    // Stage A: ray origin and the four slab numerators
    always_comb begin
        logic signed [NW-1:0] mx, my, sx, sy, hw, hh, ox, oy, gx, gy;
        mx = NW'(i_in.mov_x);
        my = NW'(i_in.mov_y);
        sx = NW'(i_in.st_x);
        sy = NW'(i_in.st_y);
        hw = NW'(i_in.mov_w >> 1);
        hh = NW'(i_in.mov_h >> 1);
        ox = mx + hw;
        oy = my + hh;
        gx = sx - hw;
        gy = sy - hh;
        n_a.num[0] = gx - ox;
        n_a.num[1] = gx + NW'(i_in.st_w) + NW'(i_in.mov_w) - ox;
        n_a.num[2] = gy - oy;
        n_a.num[3] = gy + NW'(i_in.st_h) + NW'(i_in.mov_h) - oy;
        n_a.ox = (CW+1)'(ox);
        n_a.oy = (CW+1)'(oy);
        n_a.vx = i_in.vel_x;
        n_a.vy = i_in.vel_y;
        n_a.vz = (i_in.vel_x == '0) && (i_in.vel_y == '0);
    end

    // Stage B: magnitudes, signs and the zero-velocity and zero-over-zero rejects
    always_comb begin
        logic [3:0] nz;
        logic       zz;
        for (int i = 0; i < 4; i++) begin
            n_b_side.nneg[i] = r_a.num[i][NW-1];
            n_b_mag[i] = MB'(r_a.num[i][NW-1] ? -r_a.num[i] : r_a.num[i]);
            nz[i] = (r_a.num[i] == '0);
        end
        n_b_side.dzx   = (r_a.vx == '0);
        n_b_side.dzy   = (r_a.vy == '0);
        n_b_side.vxneg = r_a.vx[CW-1];
        n_b_side.vyneg = r_a.vy[CW-1];
        n_b_side.ax    = r_a.vx[CW-1] ? CW'(-r_a.vx) : CW'(r_a.vx);
        n_b_side.ay    = r_a.vy[CW-1] ? CW'(-r_a.vy) : CW'(r_a.vy);
        n_b_side.ox    = r_a.ox;
        n_b_side.oy    = r_a.oy;
        zz = ((nz[0] || nz[1]) && n_b_side.dzx) || ((nz[2] || nz[3]) && n_b_side.dzy);
        n_b_side.ok = !r_a.vz && !zz;
    end

    // Slab divisions: x entry, x exit, y entry, y exit
    for (genvar i = 0; i < 4; i++) begin : g_div
        sac_div #(
            .CW (CW),
            .FB (FB)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_mag (r_b_mag[i]),
            .i_den ((i < 2) ? r_b_side.ax : r_b_side.ay),
            .o_quo (w_quo[i])
        );
    end

    // Stage C: signed, saturated times
    always_comb begin
        n_c       = '0;
        n_c.ok    = r_sd[QB-1].ok;
        n_c.vxneg = r_sd[QB-1].vxneg;
        n_c.vyneg = r_sd[QB-1].vyneg;
        n_c.ox    = r_sd[QB-1].ox;
        n_c.oy    = r_sd[QB-1].oy;
        n_c.ax    = r_sd[QB-1].ax;
        n_c.ay    = r_sd[QB-1].ay;
        n_c.enx = f_time(w_quo[0], r_sd[QB-1].nneg[0] ^ r_sd[QB-1].vxneg, r_sd[QB-1].dzx);
        n_c.exx = f_time(w_quo[1], r_sd[QB-1].nneg[1] ^ r_sd[QB-1].vxneg, r_sd[QB-1].dzx);
        n_c.eny = f_time(w_quo[2], r_sd[QB-1].nneg[2] ^ r_sd[QB-1].vyneg, r_sd[QB-1].dzy);
        n_c.exy = f_time(w_quo[3], r_sd[QB-1].nneg[3] ^ r_sd[QB-1].vyneg, r_sd[QB-1].dzy);
    end

    // Stage D: order entry before exit on each axis
    always_comb begin
        n_d = r_c;
        if (r_c.enx > r_c.exx) begin
            n_d.enx = r_c.exx;
            n_d.exx = r_c.enx;
        end
        if (r_c.eny > r_c.exy) begin
            n_d.eny = r_c.exy;
            n_d.exy = r_c.eny;
        end
    end

    // Stage E: interval overlap and axis order
    always_comb begin
        n_e      = r_d;
        n_e.disj = (r_d.enx > r_d.exy) || (r_d.eny > r_d.exx);
        n_e.gt   = r_d.enx > r_d.eny;
        n_e.lt   = r_d.enx < r_d.eny;
        n_e.xlt  = r_d.exx < r_d.exy;
    end

    // Stage F: entry and exit times
    always_comb begin
        n_f      = r_e;
        n_f.tin  = r_e.gt ? r_e.enx : r_e.eny;
        n_f.tout = r_e.xlt ? r_e.exx : r_e.exy;
        n_f.tb   = n_f.tin[TIME_W-1] ? (TIME_W-1)'(-n_f.tin) : (TIME_W-1)'(n_f.tin);
    end

    // Stage G: partial products of speed and entry time
    always_comb begin
        n_g     = r_f;
        n_g.pxl = (CW+BL_W)'(r_f.ax) * (CW+BL_W)'(r_f.tb[BL_W-1:0]);
        n_g.pyl = (CW+BL_W)'(r_f.ay) * (CW+BL_W)'(r_f.tb[BL_W-1:0]);
        n_g.pxh = PH'(r_f.ax) * PH'(r_f.tb[TIME_W-2:BL_W]);
        n_g.pyh = PH'(r_f.ay) * PH'(r_f.tb[TIME_W-2:BL_W]);
    end

    // Stage H: combine products into displacement magnitudes
    always_comb begin
        n_h      = r_g;
        n_h.magx = f_mag((PW'(r_g.pxh) << BL_W) + PW'(r_g.pxl));
        n_h.magy = f_mag((PW'(r_g.pyh) << BL_W) + PW'(r_g.pyl));
    end

    // Result: contact point, normal and clean-up of the reject cases
    always_comb begin
        logic signed [SW-1:0] oxe, oye, mgx, mgy, sumx, sumy;
        oxe  = SW'(r_h.ox);
        oye  = SW'(r_h.oy);
        mgx  = SW'(r_h.magx);
        mgy  = SW'(r_h.magy);
        sumx = (r_h.vxneg ^ r_h.tin[TIME_W-1]) ? oxe - mgx : oxe + mgx;
        sumy = (r_h.vyneg ^ r_h.tin[TIME_W-1]) ? oye - mgy : oye + mgy;
        w_res = '0;
        if (r_h.ok && !r_h.disj) begin
            w_res.ht = f_satc(SW'(r_h.tin));
            if (!r_h.tout[TIME_W-1]) begin
                w_res.cx  = f_satc(sumx);
                w_res.cy  = f_satc(sumy);
                w_res.hit = r_h.tin < T_ONE;
                if (r_h.gt) begin
                    w_res.code = r_h.vxneg ? NRM_PX : NRM_MX;
                end else if (r_h.lt) begin
                    w_res.code = r_h.vyneg ? NRM_PY : NRM_MY;
                end else begin
                    w_res.code = NRM_NONE;
                end
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            for (int k = 0; k < QB; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in.valid;
            r_b_vld <= r_a_vld;
            r_dv[0] <= r_b_vld;
            for (int k = 1; k < QB; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_c_vld <= r_dv[QB-1];
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= n_a;
            r_b_mag  <= n_b_mag;
            r_b_side <= n_b_side;
            r_sd[0]  <= r_b_side;
            for (int k = 1; k < QB; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
            r_g <= n_g;
            r_h <= n_h;
        end
    end

    // Output register with one skid entry
    always_comb begin
        n_ov  = r_ov;
        n_sv  = r_sv;
        n_od  = r_od;
        n_skd = r_skd;
        if (r_sv) begin
            if (o_out.ready) begin
                n_od = r_skd;
                n_ov = 1'b1;
                n_sv = 1'b0;
            end
        end else if (!r_ov || o_out.ready) begin
            n_ov = w_push;
            n_od = w_res;
        end else if (w_push) begin
            n_sv  = 1'b1;
            n_skd = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od  <= n_od;
        r_skd <= n_skd;
    end

    assign o_out.valid       = r_ov;
    assign o_out.hit         = r_od.hit;
    assign o_out.contact_x   = r_od.cx;
    assign o_out.contact_y   = r_od.cy;
    assign o_out.normal_code = r_od.code;
    assign o_out.hit_time    = r_od.ht;

    // The skid entry only holds a result behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry valid while output register is empty");

    // The skid entry fills only when the receiver stalled a waiting result
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !o_out.ready))
        else $error("skid entry filled without a stall");

    // A rejected pair yields an all-zero result
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_h_vld && !r_h.ok) |-> (w_res == '0))
        else $error("rejected pair produced a nonzero result");

endmodule
